// ----- hdl/rrp_pkg.sv -----
package rrp_pkg;

  // Default widths of the header count and argument length.
  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned LenBitsDefault   = 24;

  // Port field widths.
  localparam int unsigned KindW     = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IndexW    = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned LengthW   = 24;
  localparam int unsigned ErrW      = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 24;

  // Limit register reset values.
  localparam logic [CountW-1:0]  CountLimitReset  = 16'd1024;
  localparam logic [LengthW-1:0] LengthLimitReset = 24'hFF_FFFF;

  // Framing characters.
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNT_LIMIT  = 1'b0,
    CFG_LENGTH_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    K_FRAME  = 3'd0,
    K_DATA   = 3'd1,
    K_ARGEND = 3'd2,
    K_REQEND = 3'd3,
    K_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    E_NONE   = 3'd0,
    E_LEAD   = 3'd1,
    E_DIGIT  = 3'd2,
    E_CRLF   = 3'd3,
    E_UNTERM = 3'd4,
    E_LIMIT  = 3'd5
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data_byte;
    logic [IndexW-1:0]  arg_index;
    logic [CountW-1:0]  arg_count;
    logic [LengthW-1:0] arg_length;
    err_e               error_code;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0]  count_limit;
    logic [LengthW-1:0] length_limit;
  } limits_t;

endpackage

// ----- hdl/resp_request_parser_core.sv -----
// Registers: the input register loads at the accept edge and the result register loads
// when the parser steps, which waits while the result register holds an untaken result.
// Throughput: one byte per cycle while the output is not stalled; the parser step and the
// times-ten accumulate sit between the two registers, so back-to-back bytes pass without bubbles.
// Reset: rst_ni is asynchronous, active low; it empties both registers, sets the parser to
// expect '*', clears all counters, and loads the limits with 1024 and 16777215.
module resp_request_parser_core
  import rrp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault,
  parameter int unsigned LEN_BITS   = LenBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // limit registers
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // byte stream in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    in_byte_i,
  // classified bytes out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KindW-1:0]    kind_o,
  output logic [ByteW-1:0]    data_byte_o,
  output logic [IndexW-1:0]   arg_index_o,
  output logic [CountW-1:0]   arg_count_o,
  output logic [LengthW-1:0]  arg_length_o,
  output logic [ErrW-1:0]     error_code_o
);

  limits_t          limits;
  result_t          step_result;
  result_t          out_result;
  logic             out_busy;

  // Input register: one byte waiting for the parser step.
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_take;
  logic             advance;

  // The parser steps whenever a byte waits and the result register can take it.
  assign advance    = in_valid_q && !out_busy;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= in_byte_i;
  end

  rrp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .limits_o    (limits)
  );

  // Phase FSM, number accumulator and argument counters.
  rrp_parser #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .limits_i (limits),
    .result_o (step_result)
  );

  rrp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (out_busy),
    .result_o    (out_result)
  );

  assign kind_o       = out_result.kind;
  assign data_byte_o  = out_result.data_byte;
  assign arg_index_o  = out_result.arg_index;
  assign arg_count_o  = out_result.arg_count;
  assign arg_length_o = out_result.arg_length;
  assign error_code_o = out_result.error_code;

endmodule

// ----- hdl/rrp_cfg_regs.sv -----
module rrp_cfg_regs
  import rrp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output limits_t             limits_o
);

  limits_t limits_q, limits_d;

  always_comb begin
    limits_d = limits_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COUNT_LIMIT:  limits_d.count_limit  = cfg_data_i[CountW-1:0];
        CFG_LENGTH_LIMIT: limits_d.length_limit = cfg_data_i[LengthW-1:0];
        default:          limits_d = limits_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.count_limit  <= CountLimitReset;
      limits_q.length_limit <= LengthLimitReset;
    end else begin
      limits_q <= limits_d;
    end
  end

  assign limits_o = limits_q;

endmodule

// ----- hdl/rrp_parser.sv -----
module rrp_parser
  import rrp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault,
  parameter int unsigned LEN_BITS   = LenBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  limits_t          limits_i,
  output result_t          result_o
);

  localparam int unsigned AccW = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam int unsigned ProdW = AccW + 4;
  localparam int unsigned CmpW = (ProdW > LengthW) ? ProdW : LengthW;

  localparam logic [CmpW-1:0] CountMax = {{(CmpW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
  localparam logic [CmpW-1:0] LenMax   = {{(CmpW-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};

  typedef enum logic [8:0] {
    PH_STAR    = 9'b000000001,
    PH_CNT_DIG = 9'b000000010,
    PH_CNT_LF  = 9'b000000100,
    PH_DOLLAR  = 9'b000001000,
    PH_LEN_DIG = 9'b000010000,
    PH_LEN_LF  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_END_CR  = 9'b010000000,
    PH_END_LF  = 9'b100000000
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [AccW-1:0]       acc_q, acc_d;
  logic [COUNT_BITS-1:0] total_q, total_d, total_mid;
  logic [COUNT_BITS-1:0] pos_q, pos_d, pos_mid;
  logic [LEN_BITS-1:0]   left_q, left_d, left_dec;
  logic [LEN_BITS-1:0]   len_q, len_d, len_out;

  logic                  digit;
  logic [3:0]            digit_val;
  logic [ProdW-1:0]      acc_ext, acc_next;
  logic [CmpW-1:0]       cnt_reg, len_reg, cnt_lim, len_lim, lim, acc_cmp;
  kind_e                 kind;
  err_e                  err;
  logic [ByteW-1:0]      data;
  logic                  finish;

  assign digit     = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign digit_val = 4'(byte_i - ChZero);
  assign acc_ext   = ProdW'(acc_q);
  // acc * 10 + digit
  assign acc_next  = (acc_ext << 3) + (acc_ext << 1) + ProdW'(digit_val);
  assign acc_cmp   = CmpW'(acc_next);

  assign cnt_reg = CmpW'(limits_i.count_limit);
  assign len_reg = CmpW'(limits_i.length_limit);
  assign cnt_lim = (cnt_reg > CountMax) ? CountMax : cnt_reg;
  assign len_lim = (len_reg > LenMax) ? LenMax : len_reg;
  assign lim     = (phase_q == PH_CNT_DIG) ? cnt_lim : len_lim;

  assign left_dec = (left_q != '0) ? left_q - LEN_BITS'(1) : left_q;

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    total_mid = total_q;
    pos_mid   = pos_q;
    left_d    = left_q;
    len_d     = len_q;
    kind      = K_FRAME;
    err       = E_NONE;
    data      = '0;
    len_out   = '0;
    finish    = 1'b0;

    unique case (phase_q)
      PH_STAR: begin
        if (byte_i == ChStar) begin
          phase_d = PH_CNT_DIG;
          acc_d   = '0;
        end else begin
          err = E_LEAD;
        end
      end
      PH_CNT_DIG, PH_LEN_DIG: begin
        if (digit) begin
          acc_d = AccW'(acc_next);
          if (acc_cmp > lim) err = E_LIMIT;
        end else if (byte_i == ChCr) begin
          phase_d = (phase_q == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
        end else begin
          err = E_DIGIT;
        end
      end
      PH_CNT_LF: begin
        if (byte_i != ChLf) begin
          err = E_CRLF;
        end else begin
          total_mid = COUNT_BITS'(acc_q);
          pos_mid   = '0;
          if (total_mid == '0) begin
            kind   = K_REQEND;
            finish = 1'b1;
          end else begin
            phase_d = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (byte_i == ChDollar) begin
          phase_d = PH_LEN_DIG;
          acc_d   = '0;
        end else begin
          err = E_LEAD;
        end
      end
      PH_LEN_LF: begin
        if (byte_i != ChLf) begin
          err = E_CRLF;
        end else begin
          len_d   = LEN_BITS'(acc_q);
          left_d  = LEN_BITS'(acc_q);
          phase_d = (LEN_BITS'(acc_q) == '0) ? PH_END_CR : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        kind   = K_DATA;
        data   = byte_i;
        left_d = left_dec;
        if (left_dec == '0) phase_d = PH_END_CR;
      end
      PH_END_CR: begin
        if (byte_i == ChCr) phase_d = PH_END_LF;
        else                err     = E_UNTERM;
      end
      PH_END_LF: begin
        if (byte_i != ChLf) begin
          err = E_UNTERM;
        end else begin
          len_out = len_q;
          if (({1'b0, pos_q} + (COUNT_BITS+1)'(1)) >= {1'b0, total_q}) begin
            kind   = K_REQEND;
            finish = 1'b1;
          end else begin
            kind    = K_ARGEND;
            phase_d = PH_DOLLAR;
          end
        end
      end
      default: err = E_LEAD;
    endcase

    if (err != E_NONE) begin
      kind    = K_ERROR;
      data    = '0;
      len_out = '0;
    end

    total_d = total_mid;
    pos_d   = pos_mid;
    if ((err != E_NONE) || finish) begin
      phase_d = PH_STAR;
      acc_d   = '0;
      total_d = '0;
      pos_d   = '0;
      left_d  = '0;
      len_d   = '0;
    end else if (kind == K_ARGEND) begin
      pos_d = pos_mid + COUNT_BITS'(1);
    end
  end

  always_comb begin
    result_o.kind       = kind;
    result_o.data_byte  = data;
    result_o.arg_index  = IndexW'(pos_mid);
    result_o.arg_count  = CountW'(total_mid);
    result_o.arg_length = LengthW'(len_out);
    result_o.error_code = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STAR;
      acc_q   <= '0;
      total_q <= '0;
      pos_q   <= '0;
      left_q  <= '0;
      len_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      total_q <= total_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      len_q   <= len_d;
    end
  end

endmodule

// ----- hdl/rrp_out_reg.sv -----
module rrp_out_reg
  import rrp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output logic    busy_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // Busy: holding a result that is not taken this cycle.
  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i)           valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
